FILE: rtl/ntpcal_pkg.sv
// ----------------------------------------------------------------------------
// ntpcal_pkg: shared types and constants for the ntp seconds to calendar block
// Holds the sequencer state type, the time constants and the month length table.
// ----------------------------------------------------------------------------
`default_nettype none

package ntpcal_pkg;

  // time constants in seconds
  localparam logic [31:0] SecsPerDay    = 32'd86400;
  localparam logic [31:0] SecsPerHour   = 32'd3600;
  localparam logic [31:0] SecsPerMinute = 32'd60;
  localparam logic [31:0] SecsCommonYr  = 32'd31536000;
  localparam logic [31:0] SecsLeapYr    = 32'd31622400;

  // epoch year and its position in the leap cycles
  localparam logic [10:0] EpochYear   = 11'd1900;
  localparam logic [1:0]  EpochMod4   = 2'd0;
  localparam logic [6:0]  EpochMod100 = 7'd0;
  localparam logic [8:0]  EpochMod400 = 9'd300;

  // quotient bit counts of the three restoring divisions, minus one
  localparam logic [3:0] DayTopBit  = 4'd8;
  localparam logic [3:0] HourTopBit = 4'd4;
  localparam logic [3:0] MinTopBit  = 4'd5;

  // widths of the packed result
  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_MONTH,
    ST_FINISH
  } ntpcal_state_t;

  // days in a month, 1 is january
  function automatic logic [31:0] month_len(input logic [3:0] mon, input logic leap);
    logic [31:0] len;
    len = 32'd31;
    unique case (mon)
      4'd2:    len = leap ? 32'd29 : 32'd28;
      4'd4:    len = 32'd30;
      4'd6:    len = 32'd30;
      4'd9:    len = 32'd30;
      4'd11:   len = 32'd30;
      default: len = 32'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ntp_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar: ntp whole seconds to gregorian utc date and time
// Iterative converter built around one shared 32-bit compare and subtract unit.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the s_axis channel carries the 32-bit seconds field of an ntp
//   timestamp (epoch 1900-01-01 00:00:00). One result per request leaves on
//   the m_axis channel with year, month, day of month, day of year, hour,
//   minute, second and the leap year flag.
//   Steps: one compare and subtract step per cycle. The year walk subtracts
//   one whole year per step until less than a year remains, the day, hour
//   and minute divisions yield 9, 5 and 6 quotient bits one bit per step,
//   the month walk subtracts month lengths until the day falls inside one,
//   and the result is then loaded into the output register once it is free.
//   s_axis_tready is high only while idle, so one request is in work at a
//   time and the next one is taken only after the result is loaded.
//   The output register holds a finished result until taken; a new request is
//   accepted meanwhile, and its result waits in the last step while the
//   receiver stalls.
//   Reset (rst, synchronous) drops any request in work and any held result.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_seconds_to_calendar
  import ntpcal_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,   // ntp_seconds[31:0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // year[10:0], month[14:11], day_of_month[19:15], day_of_year[28:20],
  // hour[33:29], minute[39:34], second[45:40], is_leap_year[46], zero[47]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  ntpcal_state_t state, state_next;

  logic [31:0] acc;
  logic [10:0] year;
  logic [1:0]  y4;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [3:0]  k;
  logic [8:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [5:0]  sec_r;
  logic [3:0]  month_r;
  logic [4:0]  dom_r;

  logic        leap;
  logic [31:0] operand;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] acc_after;
  logic        out_free;
  logic [8:0]  doy;

  // gregorian leap test from the cycle counters
  assign leap = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));

  // operand of the shared unit
  always_comb begin
    operand = '0;
    case (state)
      ST_YEAR:  operand = leap ? SecsLeapYr : SecsCommonYr;
      ST_DAY:   operand = SecsPerDay << k;
      ST_HOUR:  operand = SecsPerHour << k;
      ST_MIN:   operand = SecsPerMinute << k;
      ST_MONTH: operand = month_len(month_r, leap);
      default:  operand = '0;
    endcase
  end

  // shared compare and subtract unit
  assign diff      = {1'b0, acc} - {1'b0, operand};
  assign ge        = !diff[32];
  assign acc_after = ge ? diff[31:0] : acc;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign doy      = day_q + 9'd1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_axis_tvalid) state_next = ST_YEAR;
      ST_YEAR:   if (!ge) state_next = ST_DAY;
      ST_DAY:    if (k == 4'd0) state_next = ST_HOUR;
      ST_HOUR:   if (k == 4'd0) state_next = ST_MIN;
      ST_MIN:    if (k == 4'd0) state_next = ST_MONTH;
      ST_MONTH:  if (!ge) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        acc     <= s_axis_tdata;
        year    <= EpochYear;
        y4      <= EpochMod4;
        y100    <= EpochMod100;
        y400    <= EpochMod400;
        k       <= DayTopBit;
        month_r <= 4'd1;
      end
      ST_YEAR: begin
        acc <= acc_after;
        if (ge) begin
          year <= year + 11'd1;
          y4   <= y4 + 2'd1;
          y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
          y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
        end
      end
      ST_DAY: begin
        acc   <= acc_after;
        day_q <= {day_q[7:0], ge};
        k     <= (k == 4'd0) ? HourTopBit : k - 4'd1;
      end
      ST_HOUR: begin
        acc    <= acc_after;
        hour_q <= {hour_q[3:0], ge};
        k      <= (k == 4'd0) ? MinTopBit : k - 4'd1;
      end
      ST_MIN: begin
        min_q <= {min_q[4:0], ge};
        if (k == 4'd0) begin
          // seconds are what remains; reload with day count for the month walk
          sec_r <= acc_after[5:0];
          acc   <= {23'd0, day_q};
        end else begin
          acc <= acc_after;
          k   <= k - 4'd1;
        end
      end
      ST_MONTH: begin
        acc <= acc_after;
        if (ge) begin
          month_r <= month_r + 4'd1;
        end else begin
          dom_r <= acc[4:0] + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_axis_tdata <= {1'b0, leap, sec_r, min_q, hour_q, doy, dom_r, month_r, year};
    end
  end

endmodule

`default_nettype wire

FILE: sim/ntp_seconds_to_calendar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_checker: date predictor and result scoreboard
// Watches both stream channels of the converter. Every accepted request is
// turned into the expected calendar date. Every result leaving the block is
// compared field by field with the oldest expected date.
// ----------------------------------------------------------------------------

module ntp_seconds_to_calendar_checker
  import ntpcal_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // ntp_seconds[31:0]
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // year[10:0], month[14:11], day_of_month[19:15], day_of_year[28:20],
  // hour[33:29], minute[39:34], second[45:40], is_leap_year[46], zero[47]
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int unsigned         failures,
  output int unsigned         outstanding,
  output int unsigned         dates_checked
);

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [8:0]  yday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        leap;
  } cal_date_t;

  cal_date_t dates_due[$];
  cal_date_t want;

  initial begin
    failures      = 0;
    outstanding   = 0;
    dates_checked = 0;
  end

  function automatic bit gregorian_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // walk whole years off the count, then split the remaining days and seconds
  function automatic cal_date_t date_of_ntp(input logic [31:0] ntp_secs);
    int unsigned rem;
    int unsigned yr;
    int unsigned year_len;
    int unsigned days;
    int unsigned day_left;
    int unsigned mon;
    int unsigned mon_len;
    cal_date_t   d;
    rem      = ntp_secs;
    yr       = 1900;
    year_len = (gregorian_leap(yr) ? 366 : 365) * 86400;
    while (rem >= year_len) begin
      rem      = rem - year_len;
      yr       = yr + 1;
      year_len = (gregorian_leap(yr) ? 366 : 365) * 86400;
    end
    d.year   = yr[10:0];
    d.leap   = gregorian_leap(yr);
    days     = rem / 86400;
    rem      = rem % 86400;
    d.yday   = 9'(days + 1);
    d.hour   = 5'(rem / 3600);
    rem      = rem % 3600;
    d.minute = 6'(rem / 60);
    d.second = 6'(rem % 60);
    // step through the months until the day falls inside one
    day_left = days + 1;
    mon      = 1;
    mon_len  = 31;
    while (day_left > mon_len) begin
      day_left = day_left - mon_len;
      mon      = mon + 1;
      case (mon)
        2:           mon_len = d.leap ? 29 : 28;
        4, 6, 9, 11: mon_len = 30;
        default:     mon_len = 31;
      endcase
    end
    d.month = mon[3:0];
    d.mday  = day_left[4:0];
    return d;
  endfunction

  task automatic check_field(input string name, input logic [10:0] exp_val,
                             input logic [10:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      failures++;
    end
  endtask

  // results are checked before requests so a same-cycle pair stays in order
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dates_due.size() == 0) begin
          $error("date result with no request outstanding: %h", m_axis_tdata);
          failures++;
        end else begin
          want = dates_due.pop_front();
          check_field("year",         want.year,          m_axis_tdata[10:0]);
          check_field("month",        11'(want.month),    11'(m_axis_tdata[14:11]));
          check_field("day_of_month", 11'(want.mday),     11'(m_axis_tdata[19:15]));
          check_field("day_of_year",  11'(want.yday),     11'(m_axis_tdata[28:20]));
          check_field("hour",         11'(want.hour),     11'(m_axis_tdata[33:29]));
          check_field("minute",       11'(want.minute),   11'(m_axis_tdata[39:34]));
          check_field("second",       11'(want.second),   11'(m_axis_tdata[45:40]));
          check_field("is_leap_year", 11'(want.leap),     11'(m_axis_tdata[46]));
          check_field("zero pad bit", 11'd0,              11'(m_axis_tdata[47]));
          dates_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        dates_due.push_back(date_of_ntp(s_axis_tdata));
      end
      outstanding <= dates_due.size();
    end
  end

endmodule

FILE: sim/ntp_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_tb: stream testbench for the ntp to calendar block
// Drives ntp seconds values into the converter: calendar corners first, then
// random values under four mixes of sender gaps and receiver stalls, with one
// long output stall and full drains between phases. The checker module beside
// the block predicts and compares every date.
// ----------------------------------------------------------------------------

module ntp_seconds_to_calendar_tb;
  import ntpcal_pkg::*;

  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned LongHoldCycles = 600;
  localparam int unsigned RandomPerPhase = 357;
  localparam int unsigned SettleCycles   = 200;
  localparam int unsigned NumCorners     = 23;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;  // ntp_seconds[31:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // year[10:0], month[14:11], day_of_month[19:15], day_of_year[28:20],
  // hour[33:29], minute[39:34], second[45:40], is_leap_year[46], zero[47]
  logic [OutDataW-1:0] m_axis_tdata;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned dates_checked;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  logic        long_stall_req = 1'b0;

  // calendar corners, in seconds since 1900-01-01
  logic [31:0] calendar_corners [0:NumCorners-1] = '{
    32'd0,           // epoch
    32'd1,           // one second in
    32'd86399,       // end of the first day
    32'd5097599,     // 1900-02-28 23:59:59, 1900 has no leap day
    32'd5097600,     // 1900-03-01
    32'd31535999,    // last second of 1900
    32'd31536000,    // 1901-01-01
    32'd131241600,   // 1904-02-29, first leap day
    32'd157680000,   // 1904-12-31, day 366
    32'd157766399,   // last second of 1904
    32'd3155587200,  // 1999-12-31
    32'd3155673600,  // 2000-01-01
    32'd3160771200,  // 2000-02-29, leap by the 400 rule
    32'd3187209600,  // 2000-12-31, day 366
    32'd3187295999,  // last second of 2000
    32'd3187296000,  // 2001-01-01
    32'd4291747199,  // last second of 2035
    32'd4291747200,  // 2036-01-01
    32'h7FFFFFFF,
    32'h80000000,
    32'hAAAAAAAA,
    32'h55555555,
    32'hFFFFFFFF     // top of range, 2036-02-07 06:28:15
  };

  ntp_seconds_to_calendar i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ntp_seconds_to_calendar_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .failures      (failures),
    .outstanding   (outstanding),
    .dates_checked (dates_checked)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
      end else begin
        m_axis_tready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $error("no handshake for %0d cycles, %0d dates still due", IdleLimit, outstanding);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // random seconds: mostly uniform, some on day boundaries, some near the top
  function automatic logic [31:0] random_seconds();
    logic [31:0] day_start;
    case ($urandom_range(0, 3))
      0, 1: return $urandom();
      2: begin
        day_start = $urandom_range(0, 49709) * SecsPerDay;
        return day_start + ($urandom_range(0, 1) ? 32'd86399 : 32'd0);
      end
      default: return $urandom_range(32'hFFFFFFFF, 32'hFF000000);
    endcase
  endfunction

  // offer one request, with an optional idle gap first; returns on accept
  task automatic send_request(input logic [31:0] secs);
    if ($urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= secs;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
  endtask

  // stop offering and wait until every expected date has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calendar corners with no idling
    for (int i = 0; i < NumCorners; i++) begin
      send_request(calendar_corners[i]);
    end

    // long output stall while requests keep coming, then a full drain
    long_stall_req <= 1'b1;
    @(posedge clk);
    long_stall_req <= 1'b0;
    for (int i = 0; i < 8; i++) begin
      send_request(random_seconds());
    end
    drain_results();

    // random phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 63; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 63; end
        default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
      endcase
      for (int i = 0; i < RandomPerPhase; i++) begin
        send_request(random_seconds());
      end
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk);
    $display("run: %0d timestamps sent, %0d dates checked", requests_sent, dates_checked);
    $display("run: calendar corners, a long output stall, random stall and gap mixes");
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ntpcal_pkg.sv
rtl/ntp_seconds_to_calendar.sv
sim/ntp_seconds_to_calendar_checker.sv
sim/ntp_seconds_to_calendar_tb.sv
